### hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define FMRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked on the next edge.
`define FMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fmrc_pkg.sv
package fmrc_pkg;

    localparam int STREAMS_DEFAULT = 65536;

    localparam logic [1:0] FUNC_BYTE        = 2'd0;
    localparam logic [1:0] FUNC_READ_STREAM = 2'd1;
    localparam logic [1:0] FUNC_READ_TOTAL  = 2'd2;

    localparam logic [2:0] HDR_LEN_FIRST = 3'd2;
    localparam logic [2:0] HDR_LAST      = 3'd5;

    localparam logic [7:0] TYPE_ACCEPT   = 8'h41;
    localparam logic [7:0] TYPE_CANCEL   = 8'h43;
    localparam logic [7:0] TYPE_EXECUTE  = 8'h45;
    localparam logic [7:0] TYPE_SYSTEM   = 8'h53;
    localparam logic [7:0] TYPE_REPLACE  = 8'h55;

    localparam logic [16:0] TYPE_POS     = 17'd3;
    localparam logic [16:0] SHARES_FIRST = 17'd26;
    localparam logic [16:0] SHARES_LAST  = 17'd29;
    localparam logic [15:0] MIN_LEN      = 16'd2;
    localparam logic [15:0] MIN_EXEC_LEN = 16'd28;

    typedef enum logic [2:0] {
        KIND_READOUT   = 3'd0,
        KIND_ACCEPTED  = 3'd1,
        KIND_CANCELED  = 3'd2,
        KIND_EXECUTED  = 3'd3,
        KIND_SYSTEM    = 3'd4,
        KIND_REPLACED  = 3'd5,
        KIND_MALFORMED = 3'd6
    } kind_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  cbyte;
        logic [15:0] sid;
        logic        payload;
        logic [31:0] pkts;
        logic [31:0] empties;
    } item_t;

    typedef struct packed {
        logic [16:0] pos;
        logic [15:0] len;
        logic [7:0]  mtype;
        logic [31:0] shares;
    } ctx_t;

    typedef struct packed {
        logic [31:0] accepted;
        logic [31:0] canceled;
        logic [31:0] replaced;
        logic [31:0] sys_cnt;
        logic [31:0] executed;
        logic [31:0] shares;
    } cnt_t;

    typedef struct packed {
        logic [31:0] empties;
        logic [31:0] pkts;
        logic [31:0] shares_sum;
        logic [31:0] executed;
        logic [31:0] canceled;
        logic [31:0] replaced;
        logic [31:0] sys_cnt;
        logic [31:0] accepted;
        logic [31:0] shares;
        logic [15:0] sid;
        kind_t       kind;
    } res_t;

endpackage

### hw/rtl/feed_message_reassembly_counter_unit.sv
// Channel   Beat fields (lowest bit first)
// s_axis    tuser: func[1:0]; tdata: capture_byte[7:0], stream_index[15:0]
// m_axis    tuser: event_kind[2:0]; tdata: stream_id, message_shares, accepted,
//           sys_msg, replaced, canceled, executed counts, shares_sum,
//           packets_seen, empty_packet_count
// One beat per cycle unless stalled or clearing; results pass p, u, out registers.
// Throughput is set by the single read and write port of the per-stream memories;
// a write-to-read bypass covers back-to-back bytes of one stream.
// After reset a clearing pass writes zeros to all STREAMS entries, one per cycle,
// and s_tready stays low until that pass is done.
// A stall on m_tready holds the whole pipeline.
`include "assert_macros.svh"

module feed_message_reassembly_counter_unit
    import fmrc_pkg::*;
#(
    parameter int STREAMS = STREAMS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // capture_byte[7:0], stream_index[23:8]
    input  logic [1:0]   s_tuser,   // func[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [303:0] m_tdata,   // stream_id, shares, accepted, system, replaced,
                                    // canceled, executed, shares_sum, packets, empties
    output logic [2:0]   m_tuser    // event_kind[2:0]
);

    localparam int SLOT_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / STREAMS);
    localparam logic [31:0] STREAMS_C = 32'(STREAMS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STREAMS - 1);

    logic              adv, accept;
    item_t             in_item;
    item_t             p_item_reg, u_item_reg;
    logic              p_valid_reg, u_valid_reg;
    logic [48:0]       p_prod_reg;
    logic [SLOT_W-1:0] u_slot_reg, p_slot;
    logic [15:0]       p_q;
    logic [32:0]       p_rem;
    logic              clr_busy_reg;
    logic [SLOT_W-1:0] clr_addr_reg;

    ctx_t              ctx_rd, ctx_fwd, ctx_new;
    cnt_t              cnt_rd, cnt_fwd, cnt_new;
    logic              ctx_we, cnt_we, upd_res_valid;
    res_t              upd_res;
    logic              ctx_byp_valid_reg, cnt_byp_valid_reg;
    logic [SLOT_W-1:0] ctx_byp_addr_reg, cnt_byp_addr_reg;
    ctx_t              ctx_byp_reg;
    cnt_t              cnt_byp_reg;

    logic              ctx_wen, cnt_wen;
    logic [SLOT_W-1:0] waddr;
    ctx_t              ctx_wdata;
    cnt_t              cnt_wdata;

    res_t              out_reg;
    logic              out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !clr_busy_reg;
    assign accept   = s_tvalid && s_tready;

    fmrc_hdr u_hdr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (s_tuser),
        .cbyte        (s_tdata[7:0]),
        .stream_index (s_tdata[23:8]),
        .item         (in_item)
    );

    // Stream id modulo STREAMS by reciprocal: the quotient is off by at most one.
    always_comb
    begin
        p_q   = p_prod_reg[47:32];
        p_rem = {17'd0, p_item_reg.sid} - (33'(p_q) * 33'(STREAMS_C));
        if (p_rem >= 33'(STREAMS_C))
        begin
            p_rem = p_rem - 33'(STREAMS_C);
        end
        p_slot = SLOT_W'(p_rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= accept;
            u_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_item_reg <= in_item;
            p_prod_reg <= 49'(in_item.sid) * 49'(RECIP);
            u_item_reg <= p_item_reg;
            u_slot_reg <= p_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            if (clr_addr_reg == LAST_SLOT)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign ctx_fwd = (ctx_byp_valid_reg && ctx_byp_addr_reg == u_slot_reg) ? ctx_byp_reg : ctx_rd;
    assign cnt_fwd = (cnt_byp_valid_reg && cnt_byp_addr_reg == u_slot_reg) ? cnt_byp_reg : cnt_rd;

    fmrc_upd u_upd (
        .clk       (clk),
        .rst_n     (rst_n),
        .active    (u_valid_reg),
        .commit    (adv),
        .item      (u_item_reg),
        .ctx_in    (ctx_fwd),
        .cnt_in    (cnt_fwd),
        .ctx_out   (ctx_new),
        .ctx_we    (ctx_we),
        .cnt_out   (cnt_new),
        .cnt_we    (cnt_we),
        .res       (upd_res),
        .res_valid (upd_res_valid)
    );

    assign ctx_wen   = clr_busy_reg || (adv && ctx_we);
    assign cnt_wen   = clr_busy_reg || (adv && cnt_we);
    assign waddr     = clr_busy_reg ? clr_addr_reg : u_slot_reg;
    assign ctx_wdata = clr_busy_reg ? '0 : ctx_new;
    assign cnt_wdata = clr_busy_reg ? '0 : cnt_new;

    fmrc_ram #(.WIDTH($bits(ctx_t)), .DEPTH(STREAMS)) u_ctx_ram (
        .clk   (clk),
        .we    (ctx_wen),
        .waddr (waddr),
        .wdata (ctx_wdata),
        .re    (adv && p_valid_reg),
        .raddr (p_slot),
        .rdata (ctx_rd)
    );

    fmrc_ram #(.WIDTH($bits(cnt_t)), .DEPTH(STREAMS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_wen),
        .waddr (waddr),
        .wdata (cnt_wdata),
        .re    (adv && p_valid_reg),
        .raddr (p_slot),
        .rdata (cnt_rd)
    );

    // The read issued in the same cycle as a write misses it; hold that write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_byp_valid_reg <= 1'b0;
            cnt_byp_valid_reg <= 1'b0;
        end
        else if (clr_busy_reg)
        begin
            ctx_byp_valid_reg <= 1'b0;
            cnt_byp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctx_byp_valid_reg <= ctx_wen;
            cnt_byp_valid_reg <= cnt_wen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_byp_addr_reg <= u_slot_reg;
            cnt_byp_addr_reg <= u_slot_reg;
            ctx_byp_reg      <= ctx_new;
            cnt_byp_reg      <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= u_valid_reg && upd_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= upd_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.empties, out_reg.pkts, out_reg.shares_sum, out_reg.executed,
                       out_reg.canceled, out_reg.replaced, out_reg.sys_cnt, out_reg.accepted,
                       out_reg.shares, out_reg.sid};

    `FMRC_ASSERT(a_no_accept_clear, !(clr_busy_reg && s_tready), "input taken during clear")
    `FMRC_ASSERT(a_slot_range, !p_valid_reg || (32'(p_slot) < STREAMS_C), "slot out of range")
    `FMRC_ASSERT_NEXT(a_stall_holds, u_valid_reg && !adv, u_valid_reg, "stalled item lost")
    `FMRC_ASSERT_NEXT(a_write_bypassed, adv && ctx_we && u_valid_reg && !clr_busy_reg,
                      ctx_byp_valid_reg, "context write not held for bypass")

endmodule

### hw/rtl/fmrc_ram.sv
module fmrc_ram
    import fmrc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/fmrc_hdr.sv
module fmrc_hdr
    import fmrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  func,
    input  logic [7:0]  cbyte,
    input  logic [15:0] stream_index,
    output item_t       item
);

    logic [2:0]  hpos_reg, hpos_next;
    logic [15:0] hstream_reg, hstream_next;
    logic [31:0] hlen_reg, hlen_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] pkts_reg, pkts_next;
    logic [31:0] empties_reg, empties_next;
    logic [31:0] full_len;

    always_comb
    begin
        hpos_next    = hpos_reg;
        hstream_next = hstream_reg;
        hlen_next    = hlen_reg;
        remain_next  = remain_reg;
        pkts_next    = pkts_reg;
        empties_next = empties_reg;
        full_len     = {hlen_reg[23:0], cbyte};

        item.func    = func;
        item.cbyte   = cbyte;
        item.sid     = (func == FUNC_READ_STREAM) ? stream_index : hstream_reg;
        item.payload = 1'b0;
        item.pkts    = pkts_reg;
        item.empties = empties_reg;

        if (func == FUNC_BYTE)
        begin
            priority if (remain_reg != 32'd0)
            begin
                item.payload = 1'b1;
                remain_next  = remain_reg - 32'd1;
            end
            else if (hpos_reg < HDR_LEN_FIRST)
            begin
                hstream_next = (hpos_reg == 3'd0) ? {8'h00, cbyte} : {hstream_reg[7:0], cbyte};
                hpos_next    = hpos_reg + 3'd1;
            end
            else if (hpos_reg < HDR_LAST)
            begin
                hlen_next = (hpos_reg == HDR_LEN_FIRST) ? {24'h0, cbyte} : full_len;
                hpos_next = hpos_reg + 3'd1;
            end
            else
            begin
                hlen_next = full_len;
                hpos_next = 3'd0;
                pkts_next = pkts_reg + 32'd1;
                if (full_len == 32'd0)
                begin
                    empties_next = empties_reg + 32'd1;
                end
                else
                begin
                    remain_next = full_len;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpos_reg    <= 3'd0;
            hstream_reg <= 16'd0;
            hlen_reg    <= 32'd0;
            remain_reg  <= 32'd0;
            pkts_reg    <= 32'd0;
            empties_reg <= 32'd0;
        end
        else if (accept)
        begin
            hpos_reg    <= hpos_next;
            hstream_reg <= hstream_next;
            hlen_reg    <= hlen_next;
            remain_reg  <= remain_next;
            pkts_reg    <= pkts_next;
            empties_reg <= empties_next;
        end
    end

endmodule

### hw/rtl/fmrc_upd.sv
module fmrc_upd
    import fmrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  active,
    input  logic  commit,
    input  item_t item,
    input  ctx_t  ctx_in,
    input  cnt_t  cnt_in,
    output ctx_t  ctx_out,
    output logic  ctx_we,
    output cnt_t  cnt_out,
    output logic  cnt_we,
    output res_t  res,
    output logic  res_valid
);

    cnt_t        tot_reg, tot_next;
    logic [16:0] idx;
    logic        done;
    kind_t       kind;
    logic        counts;

    always_comb
    begin
        ctx_out = ctx_in;
        idx     = ctx_in.pos;
        priority if (idx == 17'd0)
        begin
            ctx_out.len    = {item.cbyte, 8'h00};
            ctx_out.mtype  = 8'h00;
            ctx_out.shares = 32'd0;
        end
        else if (idx == 17'd1)
        begin
            ctx_out.len = {ctx_in.len[15:8], ctx_in.len[7:0] | item.cbyte};
        end
        else if (idx == TYPE_POS)
        begin
            ctx_out.mtype = item.cbyte;
        end
        else if (idx >= SHARES_FIRST && idx <= SHARES_LAST)
        begin
            ctx_out.shares = {ctx_in.shares[23:0], item.cbyte};
        end
        else
        begin
            ctx_out = ctx_in;
        end

        // The message ends on its byte at offset length+1.
        done        = active && item.payload && (idx != 17'd0)
                      && (idx == {1'b0, ctx_out.len} + 17'd1);
        ctx_out.pos = done ? 17'd0 : idx + 17'd1;
        ctx_we      = active && item.payload;

        kind = KIND_MALFORMED;
        if (ctx_out.len >= MIN_LEN)
        begin
            unique case (ctx_out.mtype)
                TYPE_ACCEPT:  kind = KIND_ACCEPTED;
                TYPE_CANCEL:  kind = KIND_CANCELED;
                TYPE_EXECUTE: kind = (ctx_out.len < MIN_EXEC_LEN) ? KIND_MALFORMED
                                                                  : KIND_EXECUTED;
                TYPE_SYSTEM:  kind = KIND_SYSTEM;
                TYPE_REPLACE: kind = KIND_REPLACED;
                default:      kind = KIND_MALFORMED;
            endcase
        end
        counts = done && (kind != KIND_MALFORMED);
        cnt_we = counts;

        cnt_out  = cnt_in;
        tot_next = tot_reg;
        unique case (kind)
            KIND_ACCEPTED:
            begin
                cnt_out.accepted  = cnt_in.accepted + 32'd1;
                tot_next.accepted = tot_reg.accepted + 32'd1;
            end
            KIND_CANCELED:
            begin
                cnt_out.canceled  = cnt_in.canceled + 32'd1;
                tot_next.canceled = tot_reg.canceled + 32'd1;
            end
            KIND_EXECUTED:
            begin
                cnt_out.executed  = cnt_in.executed + 32'd1;
                cnt_out.shares    = cnt_in.shares + ctx_out.shares;
                tot_next.executed = tot_reg.executed + 32'd1;
                tot_next.shares   = tot_reg.shares + ctx_out.shares;
            end
            KIND_SYSTEM:
            begin
                cnt_out.sys_cnt  = cnt_in.sys_cnt + 32'd1;
                tot_next.sys_cnt = tot_reg.sys_cnt + 32'd1;
            end
            KIND_REPLACED:
            begin
                cnt_out.replaced  = cnt_in.replaced + 32'd1;
                tot_next.replaced = tot_reg.replaced + 32'd1;
            end
            default:
            begin
            end
        endcase

        res       = '0;
        res_valid = 1'b0;
        if (done)
        begin
            res_valid  = 1'b1;
            res.kind   = kind;
            res.sid    = item.sid;
            res.shares = (kind == KIND_EXECUTED) ? ctx_out.shares : 32'd0;
        end
        else if (active && (item.func == FUNC_READ_STREAM || item.func == FUNC_READ_TOTAL))
        begin
            res_valid      = 1'b1;
            res.kind       = KIND_READOUT;
            res.sid        = (item.func == FUNC_READ_STREAM) ? item.sid : 16'd0;
            res.accepted   = (item.func == FUNC_READ_STREAM) ? cnt_in.accepted : tot_reg.accepted;
            res.sys_cnt    = (item.func == FUNC_READ_STREAM) ? cnt_in.sys_cnt : tot_reg.sys_cnt;
            res.replaced   = (item.func == FUNC_READ_STREAM) ? cnt_in.replaced : tot_reg.replaced;
            res.canceled   = (item.func == FUNC_READ_STREAM) ? cnt_in.canceled : tot_reg.canceled;
            res.executed   = (item.func == FUNC_READ_STREAM) ? cnt_in.executed : tot_reg.executed;
            res.shares_sum = (item.func == FUNC_READ_STREAM) ? cnt_in.shares : tot_reg.shares;
            res.pkts       = item.pkts;
            res.empties    = item.empties;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg <= '0;
        end
        else if (commit && counts)
        begin
            tot_reg <= tot_next;
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fmrc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] sid;
        logic [31:0] shares;
        logic [31:0] acc;
        logic [31:0] sysc;
        logic [31:0] rep;
        logic [31:0] can;
        logic [31:0] exe;
        logic [31:0] ssum;
        logic [31:0] pkts;
        logic [31:0] emp;
    } event_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] can;
        logic [31:0] rep;
        logic [31:0] sysc;
        logic [31:0] exe;
        logic [31:0] shr;
    } tally_t;

    typedef struct packed {
        logic [31:0] pos;
        logic [15:0] len;
        logic [7:0]  mtype;
        logic [31:0] shares;
    } msg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  cbyte;
        logic [15:0] sidx;
        logic        typed;
        kind_t       kind;
        logic [15:0] sid;
        logic [31:0] pkts;
        logic [31:0] emp;
    } row_t;

    localparam int DIRECTED = 22;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [303:0] m_tdata;
    logic [2:0]   m_tuser;

    // Predictor state.
    logic [2:0]  hdr_pos;
    logic [15:0] hdr_sid;
    logic [31:0] hdr_len;
    logic [31:0] pay_left;
    msg_t        msg_ctx [65536];
    tally_t      strm_tally [65536];
    tally_t      tot_tally;
    logic [31:0] pkt_cnt;
    logic [31:0] empty_cnt;

    event_t pending_events [$];
    int     errors;
    int     checked;
    int     beats_sent;
    bit     hold_req;

    // Per-stream queues of message bytes still to be sent by the generator.
    logic [15:0] gen_sids [6] = '{16'h0000, 16'h0001, 16'h0002, 16'h1234, 16'h8000, 16'hFFFF};
    logic [7:0]  gen_bytes [6][$];

    feed_message_reassembly_counter_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void fill_tallies(inout event_t r, input tally_t t);
        r.acc  = t.acc;
        r.sysc = t.sysc;
        r.rep  = t.rep;
        r.can  = t.can;
        r.exe  = t.exe;
        r.ssum = t.shr;
        r.pkts = pkt_cnt;
        r.emp  = empty_cnt;
    endfunction

    function automatic kind_t close_message(msg_t m, logic [15:0] slot,
                                            output logic [31:0] shares);
        logic [31:0] total;
        total  = {16'd0, m.len} + 32'd2;
        shares = '0;
        if (total < 32'd4)
            return KIND_MALFORMED;
        case (m.mtype)
            TYPE_ACCEPT:
            begin
                strm_tally[slot].acc++;
                tot_tally.acc++;
                return KIND_ACCEPTED;
            end
            TYPE_CANCEL:
            begin
                strm_tally[slot].can++;
                tot_tally.can++;
                return KIND_CANCELED;
            end
            TYPE_EXECUTE:
            begin
                if (total < 32'd30)
                    return KIND_MALFORMED;
                strm_tally[slot].exe++;
                tot_tally.exe++;
                strm_tally[slot].shr += m.shares;
                tot_tally.shr += m.shares;
                shares = m.shares;
                return KIND_EXECUTED;
            end
            TYPE_SYSTEM:
            begin
                strm_tally[slot].sysc++;
                tot_tally.sysc++;
                return KIND_SYSTEM;
            end
            TYPE_REPLACE:
            begin
                strm_tally[slot].rep++;
                tot_tally.rep++;
                return KIND_REPLACED;
            end
            default: return KIND_MALFORMED;
        endcase
    endfunction

    function automatic bit reassemble_byte(logic [7:0] b, output event_t r);
        msg_t        m;
        logic [31:0] idx;
        logic [31:0] shares;
        r   = '0;
        m   = msg_ctx[hdr_sid];
        idx = m.pos;
        if (idx == 0)
        begin
            m.len    = {b, 8'd0};
            m.mtype  = '0;
            m.shares = '0;
        end
        else if (idx == 1)
        begin
            m.len[7:0] = b;
        end
        else if (idx == 3)
        begin
            m.mtype = b;
        end
        else if (idx >= 26 && idx <= 29)
        begin
            m.shares = {m.shares[23:0], b};
        end
        if (idx >= 1 && idx + 1 == {16'd0, m.len} + 32'd2)
        begin
            m.pos = 0;
            msg_ctx[hdr_sid] = m;
            r.kind   = close_message(m, hdr_sid, shares);
            r.sid    = hdr_sid;
            r.shares = shares;
            return 1'b1;
        end
        m.pos = idx + 1;
        msg_ctx[hdr_sid] = m;
        return 1'b0;
    endfunction

    function automatic bit predict_event(logic [1:0] f, logic [7:0] b, logic [15:0] idx,
                                         output event_t r);
        r = '0;
        if (f == FUNC_READ_STREAM)
        begin
            r.kind = KIND_READOUT;
            r.sid  = idx;
            fill_tallies(r, strm_tally[idx]);
            return 1'b1;
        end
        if (f == FUNC_READ_TOTAL)
        begin
            r.kind = KIND_READOUT;
            fill_tallies(r, tot_tally);
            return 1'b1;
        end
        if (f != FUNC_BYTE)
            return 1'b0;
        if (pay_left != 0)
        begin
            pay_left--;
            return reassemble_byte(b, r);
        end
        if (hdr_pos < HDR_LEN_FIRST)
        begin
            hdr_sid = {hdr_pos == 0 ? 8'd0 : hdr_sid[7:0], b};
            hdr_pos++;
        end
        else if (hdr_pos < HDR_LAST)
        begin
            hdr_len = {hdr_pos == HDR_LEN_FIRST ? 24'd0 : hdr_len[23:0], b};
            hdr_pos++;
        end
        else
        begin
            hdr_len = {hdr_len[23:0], b};
            hdr_pos = 0;
            pkt_cnt++;
            if (hdr_len == 0)
                empty_cnt++;
            else
                pay_left = hdr_len;
        end
        return 1'b0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one beat and waits a random gap; a typed row overrides the prediction.
    task automatic send_beat(logic [1:0] f, logic [7:0] b, logic [15:0] idx,
                             bit typed, event_t typed_ev);
        event_t ev;
        int     gap;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {idx, b};
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_event(f, b, idx, ev))
            pending_events.push_back(typed ? typed_ev : ev);
        beats_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(logic [1:0] f, logic [7:0] b, logic [15:0] idx);
        send_beat(f, b, idx, 1'b0, '0);
    endtask

    task automatic queue_message(int s);
        int          pick;
        int          total;
        logic [15:0] len;
        logic [7:0]  mt;
        logic [31:0] shares;
        logic [7:0]  bb;
        pick   = $urandom_range(0, 9);
        shares = $urandom;
        case (pick)
            0, 1: mt = TYPE_ACCEPT;
            2:    mt = TYPE_CANCEL;
            3, 4: mt = TYPE_EXECUTE;
            5:    mt = TYPE_SYSTEM;
            6:    mt = TYPE_REPLACE;
            9:    mt = TYPE_EXECUTE;
            default: mt = 8'($urandom);
        endcase
        if (pick == 3 || pick == 4)
            len = 16'($urandom_range(28, 32));
        else if (pick == 8)
            len = 16'($urandom_range(0, 1));
        else if (pick == 9)
            len = 16'($urandom_range(2, 27));
        else
            len = 16'($urandom_range(2, 10));
        total = len + 2;
        for (int i = 0; i < total; i++)
        begin
            bb = 8'($urandom);
            if (i == 0)
                bb = len[15:8];
            else if (i == 1)
                bb = len[7:0];
            else if (i == 3)
                bb = mt;
            else if (i >= 26 && i <= 29)
                bb = shares[8 * (29 - i) +: 8];
            gen_bytes[s].push_back(bb);
        end
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // Occasionally slips in a readout or an unused function code.
    task automatic maybe_read();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            send_random(FUNC_READ_STREAM, 8'($urandom),
                        r < 2 ? gen_sids[$urandom_range(0, 5)] : 16'($urandom));
        else if (r < 6)
            send_random(FUNC_READ_TOTAL, 8'($urandom), 16'($urandom));
        else if (r < 7)
            send_random(2'd3, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_packet();
        int          s;
        bit          noise;
        logic [15:0] sid;
        logic [31:0] plen;
        logic [7:0]  hdr [6];
        logic [7:0]  bb;
        noise = ($urandom_range(0, 19) == 0);
        s     = $urandom_range(0, 5);
        sid   = noise ? 16'($urandom) : gen_sids[s];
        plen  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        hdr   = '{sid[15:8], sid[7:0], plen[31:24], plen[23:16], plen[15:8], plen[7:0]};
        for (int i = 0; i < 6; i++)
        begin
            maybe_read();
            send_random(FUNC_BYTE, hdr[i], 16'($urandom));
        end
        for (int i = 0; i < plen; i++)
        begin
            maybe_read();
            if (noise)
            begin
                bb = 8'($urandom);
            end
            else
            begin
                if (gen_bytes[s].size() == 0)
                    queue_message(s);
                bb = gen_bytes[s].pop_front();
                // A rare corrupted byte breaks the message framing of this stream.
                if ($urandom_range(0, 199) == 0)
                    bb = 8'($urandom);
            end
            send_random(FUNC_BYTE, bb, 16'($urandom));
        end
    endtask

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        event_t got;
        event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = kind_t'(m_tuser);
            got.sid    = m_tdata[15:0];
            got.shares = m_tdata[47:16];
            got.acc    = m_tdata[79:48];
            got.sysc   = m_tdata[111:80];
            got.rep    = m_tdata[143:112];
            got.can    = m_tdata[175:144];
            got.exe    = m_tdata[207:176];
            got.ssum   = m_tdata[239:208];
            got.pkts   = m_tdata[271:240];
            got.emp    = m_tdata[303:272];
            if (pending_events.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d", got.kind);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                checked++;
                check_field("event_kind", 32'(want.kind), 32'(got.kind));
                check_field("stream_id", 32'(want.sid), 32'(got.sid));
                check_field("message_shares", want.shares, got.shares);
                check_field("accepted_count", want.acc, got.acc);
                check_field("sys_msg_count", want.sysc, got.sysc);
                check_field("replaced_count", want.rep, got.rep);
                check_field("canceled_count", want.can, got.can);
                check_field("executed_count", want.exe, got.exe);
                check_field("shares_sum", want.ssum, got.ssum);
                check_field("packets_seen", want.pkts, got.pkts);
                check_field("empty_packet_count", want.emp, got.emp);
            end
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        #8ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        row_t   rows [DIRECTED];
        event_t tev;
        int     start_beats;
        int     waited;
        bit     hold_done;
        bit     drain_done;
        rows = '{
            '{FUNC_READ_TOTAL,  8'h00, 16'h0000, 1'b1, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_READ_STREAM, 8'hFF, 16'hFFFF, 1'b1, KIND_READOUT,   16'hFFFF, 0, 0},
            '{2'd3,             8'hFF, 16'hFFFF, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h07, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_READ_TOTAL,  8'h00, 16'h0000, 1'b1, KIND_READOUT,   16'h0000, 1, 1},
            '{FUNC_BYTE,        8'hFF, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'hFF, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h05, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h01, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'hAA, 16'h0000, 1'b1, KIND_MALFORMED, 16'hFFFF, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b0, KIND_READOUT,   16'h0000, 0, 0},
            '{FUNC_BYTE,        8'h00, 16'h0000, 1'b1, KIND_MALFORMED, 16'hFFFF, 0, 0},
            '{FUNC_READ_STREAM, 8'h00, 16'hFFFF, 1'b0, KIND_READOUT,   16'h0000, 0, 0}
        };
        errors = 0;
        checked = 0;
        beats_sent = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        hdr_pos = '0;
        hdr_sid = '0;
        hdr_len = '0;
        pay_left = '0;
        tot_tally = '0;
        pkt_cnt = '0;
        empty_cnt = '0;
        for (int i = 0; i < 65536; i++)
        begin
            msg_ctx[i] = '0;
            strm_tally[i] = '0;
        end
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_BYTE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            tev = '0;
            tev.kind = rows[i].kind;
            tev.sid  = rows[i].sid;
            tev.pkts = rows[i].pkts;
            tev.emp  = rows[i].emp;
            send_beat(rows[i].func, rows[i].cbyte, rows[i].sidx, rows[i].typed, tev);
        end

        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_ITEMS)
        begin
            if (!hold_done && beats_sent - start_beats > 500)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && beats_sent - start_beats > 1100)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                drain_done = 1'b1;
            end
            send_packet();
        end
        send_random(FUNC_READ_TOTAL, 8'h00, 16'h0000);
        s_tvalid <= 1'b0;

        wait_drained();
        waited = 0;
        while (waited < 10)
        begin
            @(posedge clk);
            waited++;
        end
        $display("Sent %0d input beats, checked %0d result beats, %0d packets decoded.",
                 beats_sent, checked, pkt_cnt);
        $display("Mix covered all message kinds, readouts, a long output stall and a drain.");
        if (errors == 0 && pending_events.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
